// ===== rtl/sobv_pkg.sv =====
// Shared types and constants for the vertical-gradient Sobel edge filter.
// Used by every module in the rtl folder but sobv_ram; depends on nothing else.
package sobv_pkg;

    localparam int PIX_W       = 8;
    localparam int DIM_W       = 11;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int MIN_DIM     = 3;
    localparam int DIFF_W      = PIX_W + 1;
    localparam int SUM_W       = PIX_W + 3;
    localparam int PIX_MAX     = 255;

    localparam int CFG_ADDR_W  = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HEIGHT = 1'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_AW + 1;
    localparam int OCC_W       = FIFO_CNT_W + 1;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             row_end;
        logic             frame_end;
    } out_item_t;

    // Clamp a dimension register to MIN_DIM..max_dim and return that minus one.
    function automatic logic [COL_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] eff;
        eff = v;
        if (v < DIM_W'(MIN_DIM)) begin
            eff = DIM_W'(MIN_DIM);
        end else if (v > max_dim) begin
            eff = max_dim;
        end
        dim_last = COL_W'(eff - DIM_W'(1));
    endfunction

endpackage

// ===== rtl/sobv_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module sobv_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sobv_cell.sv =====
// One column cell of the 3x3 window: holds the upper and lower pixel of a column
// and passes them to the next older cell. Depends on sobv_pkg.
module sobv_cell (
    input  logic                                aclk,
    input  logic                                shift_en,
    input  logic [sobv_pkg::PIX_W-1:0]          upper_in,
    input  logic [sobv_pkg::PIX_W-1:0]          lower_in,
    output logic [sobv_pkg::PIX_W-1:0]          upper_out,
    output logic [sobv_pkg::PIX_W-1:0]          lower_out,
    output logic signed [sobv_pkg::DIFF_W-1:0]  diff
);
    import sobv_pkg::*;

    logic [PIX_W-1:0] upper_reg;
    logic [PIX_W-1:0] lower_reg;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            upper_reg <= upper_in;
            lower_reg <= lower_in;
        end
    end

    assign upper_out = upper_reg;
    assign lower_out = lower_reg;
    // Column contribution before weighting: upper minus lower.
    assign diff = $signed({1'b0, upper_reg}) - $signed({1'b0, lower_reg});

endmodule

// ===== rtl/sobv_fifo.sv =====
// Small result queue that decouples the filter pipeline from the output stream.
// Depends on sobv_pkg for the item type and depth.
module sobv_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  sobv_pkg::out_item_t               push_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sobv_pkg::out_item_t               out_data,
    output logic [sobv_pkg::FIFO_CNT_W-1:0]   count
);
    import sobv_pkg::*;

    out_item_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/sobel_vertical_edge_filter_top.sv =====
// Vertical-gradient Sobel edge filter, top level. Depends on sobv_pkg, sobv_ram,
// sobv_cell and sobv_fifo.
// A pixel that completes an interior window passes the stage 1 registers and the window
// cells; its result is then written into the result queue, whose head drives m_tdata.
// Throughput: one pixel per cycle while the result queue has room; the line stores are
// read once and written once per pixel, and the three-cell window shifts once per pixel.
// Reset (aresetn low, synchronous) clears counters, pipeline valids and the result
// queue and loads width 640 and height 480; line-store contents are left as they are.
module sobel_vertical_edge_filter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [sobv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sobv_pkg::DIM_W-1:0]        cfg_wdata,
    // Pixel input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sobv_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel_in
    input  logic                              s_tuser,   // [0] start_of_frame
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sobv_pkg::PIX_W-1:0]        m_tdata,   // [7:0] edge_value
    output logic                              m_tlast,   // row_end
    output logic                              m_tuser    // [0] frame_end
);
    import sobv_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers: the user must write them only while idle; not enforced.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDX_WIDTH:  width_reg  <= cfg_wdata;
                CFG_IDX_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    // The dimensions in use are the register values clamped to 3..1024.
    assign col_last = dim_last(width_reg, DIM_W'(MAX_WIDTH));
    assign row_last = ROW_W'(dim_last(height_reg, DIM_W'(MAX_HEIGHT)));

    // ------------------------------------------------------------------
    // Stage 0: accept a pixel, work out its position and read both line
    // stores at its column.
    // ------------------------------------------------------------------
    logic             s_accept;
    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic             is_last_col, is_last_row, emit;

    assign s_accept = s_tvalid && s_tready;

    // A start-of-frame pixel is taken as row 0, column 0.
    assign col_cur     = s_tuser ? '0 : col_reg;
    assign row_cur     = s_tuser ? '0 : row_reg;
    assign is_last_col = (col_cur >= col_last);
    assign is_last_row = (row_cur >= row_last);
    assign emit        = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_accept) begin
            if (is_last_col) begin
                col_next = '0;
                row_next = is_last_row ? '0 : row_cur + ROW_W'(1);
            end else begin
                col_next = col_cur + COL_W'(1);
                row_next = row_cur;
            end
        end
    end

    // Stage 1 carries the pixel and its flags while the line-store read completes.
    logic             p1_valid_reg;
    logic [PIX_W-1:0] p1_pix_reg;
    logic [COL_W-1:0] p1_col_reg;
    logic             p1_emit_reg;
    logic             p1_row_end_reg;
    logic             p1_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            p1_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_pix_reg       <= s_tdata;
            p1_col_reg       <= col_cur;
            p1_emit_reg      <= emit;
            p1_row_end_reg   <= is_last_col;
            p1_frame_end_reg <= is_last_col && is_last_row;
        end
    end

    // ------------------------------------------------------------------
    // Line stores. The upper store holds row r-2, the middle store row r-1.
    // In stage 1 the middle entry moves up and the new pixel enters the
    // middle store at the same column.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] upper_rd;
    logic [PIX_W-1:0] middle_rd;

    sobv_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_upper_store (
        .aclk    (aclk),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_col_reg),
        .wr_data (middle_rd),
        .rd_en   (s_accept),
        .rd_addr (col_cur),
        .rd_data (upper_rd)
    );

    sobv_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_middle_store (
        .aclk    (aclk),
        .wr_en   (p1_valid_reg),
        .wr_addr (p1_col_reg),
        .wr_data (p1_pix_reg),
        .rd_en   (s_accept),
        .rd_addr (col_cur),
        .rd_data (middle_rd)
    );

    // ------------------------------------------------------------------
    // Window: a chain of three column cells, newest first. Each cell holds
    // the upper-row and lower-row pixel of one column.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]         cell_upper [3];
    logic [PIX_W-1:0]         cell_lower [3];
    logic signed [DIFF_W-1:0] cell_diff  [3];

    sobv_cell u_cell0 (
        .aclk      (aclk),
        .shift_en  (p1_valid_reg),
        .upper_in  (upper_rd),
        .lower_in  (p1_pix_reg),
        .upper_out (cell_upper[0]),
        .lower_out (cell_lower[0]),
        .diff      (cell_diff[0])
    );

    sobv_cell u_cell1 (
        .aclk      (aclk),
        .shift_en  (p1_valid_reg),
        .upper_in  (cell_upper[0]),
        .lower_in  (cell_lower[0]),
        .upper_out (cell_upper[1]),
        .lower_out (cell_lower[1]),
        .diff      (cell_diff[1])
    );

    // The oldest cell's pixels leave the window; only its difference is used.
    sobv_cell u_cell2 (
        .aclk      (aclk),
        .shift_en  (p1_valid_reg),
        .upper_in  (cell_upper[1]),
        .lower_in  (cell_lower[1]),
        .upper_out (cell_upper[2]),
        .lower_out (cell_lower[2]),
        .diff      (cell_diff[2])
    );

    // Stage 2 flags travel beside the freshly shifted window.
    logic p2_valid_reg;
    logic p2_row_end_reg;
    logic p2_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else begin
            p2_valid_reg <= p1_valid_reg && p1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            p2_row_end_reg   <= p1_row_end_reg;
            p2_frame_end_reg <= p1_frame_end_reg;
        end
    end

    // ------------------------------------------------------------------
    // Kernel: columns weighted 1, 2, 1, then clamped to 0..255.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] grad_sum;
    out_item_t               result;

    assign grad_sum = SUM_W'(cell_diff[0]) + (SUM_W'(cell_diff[1]) <<< 1)
                    + SUM_W'(cell_diff[2]);

    always_comb begin
        if (grad_sum < 0) begin
            result.edge_value = '0;
        end else if (grad_sum > SUM_W'(PIX_MAX)) begin
            result.edge_value = PIX_W'(PIX_MAX);
        end else begin
            result.edge_value = grad_sum[PIX_W-1:0];
        end
        result.row_end   = p2_row_end_reg;
        result.frame_end = p2_frame_end_reg;
    end

    // ------------------------------------------------------------------
    // Result queue. The input side is ready while the queue has room for
    // every pixel still in the pipeline, so a stalled output never loses a
    // result and the input keeps flowing while results wait, until the queue is full.
    // ------------------------------------------------------------------
    out_item_t             q_data;
    logic [FIFO_CNT_W-1:0] q_count;
    logic [OCC_W-1:0]      occupancy;

    sobv_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p2_valid_reg),
        .push_data (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign occupancy = OCC_W'(q_count) + OCC_W'(p1_valid_reg) + OCC_W'(p2_valid_reg);
    assign s_tready  = (occupancy < OCC_W'(FIFO_DEPTH));

    assign m_tdata = q_data.edge_value;
    assign m_tlast = q_data.row_end;
    assign m_tuser = q_data.frame_end;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The queue never has to hold more than it was granted room for.
    a_no_overcommit: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= OCC_W'(FIFO_DEPTH))
        else $error("result queue overcommitted");

    // A frame end is always also the end of an output row.
    a_frame_end_is_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end without row end");

    // A start-of-frame pixel is processed at column 0.
    a_sof_column_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser) |=> (p1_valid_reg && (p1_col_reg == '0)))
        else $error("start of frame not taken at column 0");

    // A result enters the window stage only from an accepted interior pixel.
    a_result_from_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !emit) |=> ##1 !p2_valid_reg)
        else $error("result produced for a border pixel");

endmodule

// ===== tb/sobel_vertical_edge_filter_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sobel_vertical_edge_filter_top: streams pixel frames in and checks
// every result against a cycle-free model of the vertical Sobel filter kept in this file.
// Depends on sobv_pkg and the filter RTL only.
module sobel_vertical_edge_filter_top_test;
    import sobv_pkg::*;

    // One row of the directed stimulus: either a register write or a pixel transaction.
    // A pixel row may carry a typed-in expected result that replaces the prediction.
    typedef struct {
        bit                    is_write;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [DIM_W-1:0]      reg_val;
        logic [PIX_W-1:0]      pix;
        logic                  sof;
        bit                    typed;
        out_item_t             want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DIM_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [PIX_W-1:0]      s_tdata;   // [7:0] pixel_in
    logic                  s_tuser;   // [0] start_of_frame
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIX_W-1:0]      m_tdata;   // [7:0] edge_value
    logic                  m_tlast;   // row_end
    logic                  m_tuser;   // [0] frame_end

    // Model state: the two previous input rows, the three newest window columns and the
    // raster position, plus the model's copy of the two size registers.
    logic [PIX_W-1:0] row_two_up [MAX_WIDTH];
    logic [PIX_W-1:0] row_one_up [MAX_WIDTH];
    logic [PIX_W-1:0] win_up [3];   // index 0 is the newest column
    logic [PIX_W-1:0] win_lo [3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    out_item_t edge_results_due [$];
    stim_row_t directed_rows [$];
    int        mismatch_count = 0;

    // Set by the sender with each pixel it drives; read by the checker on acceptance.
    bit        typed_due;
    out_item_t typed_item;
    // When set, neither side inserts idle cycles.
    bit        steady;

    always #5 aclk = ~aclk;

    sobel_vertical_edge_filter_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // A size register outside 3..limit is used as the nearest end of that range.
    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned limit);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    // Advances the model by one pixel. Returns 1 when the pixel completes an interior
    // window, with the clamped gradient and the row and frame marks in res.
    function automatic bit sobel_predict(input logic [PIX_W-1:0] pix, input logic sof,
                                         output out_item_t res);
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] from_above;
        bit               last_col;
        bit               last_row;
        bit               made;
        int               acc;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (sof) begin
            col_pos = 0;
            row_pos = 0;
        end
        from_above = row_two_up[col_pos];
        row_two_up[col_pos] = row_one_up[col_pos];
        row_one_up[col_pos] = pix;
        win_up[2] = win_up[1];
        win_up[1] = win_up[0];
        win_up[0] = from_above;
        win_lo[2] = win_lo[1];
        win_lo[1] = win_lo[0];
        win_lo[0] = pix;
        last_col = (col_pos >= w - 1);
        last_row = (row_pos >= h - 1);
        made = (row_pos >= 2) && (col_pos >= 2);
        res = '0;
        if (made) begin
            // Upper row weighted 1,2,1 minus lower row weighted 1,2,1, then saturate.
            acc = int'(win_up[2]) + 2 * int'(win_up[1]) + int'(win_up[0])
                - int'(win_lo[2]) - 2 * int'(win_lo[1]) - int'(win_lo[0]);
            if (acc < 0) acc = 0;
            if (acc > PIX_MAX) acc = PIX_MAX;
            res.edge_value = acc[PIX_W-1:0];
            res.row_end    = last_col;
            res.frame_end  = last_col && last_row;
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return made;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want, input int unsigned got);
        mismatch_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    // Checker. Everything is sampled at the rising edge. Register writes and accepted pixels
    // update the model; every accepted result is matched against the oldest expectation.
    always @(posedge aclk) begin : check_proc
        out_item_t calc;
        out_item_t due;
        bit        made;
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            for (int k = 0; k < 3; k++) begin
                win_up[k] = '0;
                win_lo[k] = '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_IDX_WIDTH: begin
                        width_reg = cfg_wdata;
                    end
                    CFG_IDX_HEIGHT: begin
                        height_reg = cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                made = sobel_predict(s_tdata, s_tuser, calc);
                if (typed_due) begin
                    edge_results_due.push_back(typed_item);
                end else if (made) begin
                    edge_results_due.push_back(calc);
                end
            end
            if (m_tvalid && m_tready) begin
                if (edge_results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: result transaction with nothing expected, actual %0d",
                             $time, m_tdata);
                end else begin
                    due = edge_results_due.pop_front();
                    if (m_tdata !== due.edge_value) begin
                        report_mismatch("edge_value", 32'(due.edge_value), 32'(m_tdata));
                    end
                    if (m_tlast !== due.row_end) begin
                        report_mismatch("row_end", 32'(due.row_end), 32'(m_tlast));
                    end
                    if (m_tuser !== due.frame_end) begin
                        report_mismatch("frame_end", 32'(due.frame_end), 32'(m_tuser));
                    end
                end
            end
        end
    end

    // Idle lengths for both sides: mostly none or a few cycles, now and then a long one.
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Pixel values lean toward the saturating extremes so that both clamps get exercised.
    function automatic logic [PIX_W-1:0] pick_pixel();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 3) return '0;
        if (r < 6) return PIX_W'(PIX_MAX);
        return PIX_W'($urandom_range(0, PIX_MAX));
    endfunction

    // Receiver. The ready line moves only at the falling edge; a stall holds it low until a later
    // falling edge, so the line is never lowered and raised in the same step.
    initial begin : sink_proc
        int unsigned stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = (steady || $urandom_range(0, 3) != 0) ? 0 : pause_len();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Drives one pixel transaction, entered and left at a falling edge. During an idle gap
    // the data lines carry junk, which the block has to ignore.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic sof, input bit typed,
                              input out_item_t want);
        int unsigned gap;
        gap = steady ? 0 : pause_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= PIX_W'($urandom);
            s_tuser  <= 1'($urandom);
            repeat (gap) @(negedge aclk);
        end
        typed_due  = typed;
        typed_item = want;
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= sof;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Holds the sender off until every expected result has arrived, then waits longer still:
    // a last pixel that makes no result may still be inside the pipeline.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        typed_due = 1'b0;
        while (edge_results_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DIM_W-1:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Streams random pixels. The first one starts a frame. In noisy mode a frame boundary
    // gets an explicit start half the time and a stray mid-frame start appears now and then;
    // quiet mode lets whole frames run untouched and holds off once halfway through.
    task automatic run_stream(input int count, input bit noisy);
        logic sof;
        for (int i = 0; i < count; i++) begin
            sof = (i == 0);
            if (noisy && col_pos == 0 && row_pos == 0 && $urandom_range(0, 1) == 1) sof = 1'b1;
            if (noisy && $urandom_range(0, 99) == 0) sof = 1'b1;
            if ((!noisy && i == count / 2) || (noisy && $urandom_range(0, 249) == 0)) begin
                wait_drained();
            end
            send_pixel(pick_pixel(), sof, 1'b0, '0);
        end
    endtask

    function automatic void add_write(input logic [CFG_ADDR_W-1:0] idx,
                                      input logic [DIM_W-1:0] val);
        stim_row_t r;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        r.pix      = '0;
        r.sof      = 1'b0;
        r.typed    = 1'b0;
        r.want     = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_pixel(input logic [PIX_W-1:0] pix, input logic sof,
                                      input bit typed, input out_item_t want);
        stim_row_t r;
        r.is_write = 1'b0;
        r.reg_idx  = CFG_IDX_WIDTH;
        r.reg_val  = '0;
        r.pix      = pix;
        r.sof      = sof;
        r.typed    = typed;
        r.want     = want;
        directed_rows.push_back(r);
    endfunction

    initial begin : stim_proc
        logic [DIM_W-1:0] w_val;
        logic [DIM_W-1:0] h_val;
        int               frame_px;
        aresetn    = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = CFG_IDX_WIDTH;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        typed_due  = 1'b0;
        typed_item = '0;
        steady     = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset sizes, 640 wide: two full rows and the start of the third give the first
        // two results of the first output row; a wrong reset width would move them.
        run_stream(2 * 640 + 4, 1'b0);

        // Directed part. Both registers are written below the legal range, so the block
        // works on a 3x3 frame with exactly one result per frame.
        add_write(CFG_IDX_WIDTH, 11'd0);
        add_write(CFG_IDX_HEIGHT, 11'd2);
        // All-white upper row over an all-black lower row saturates high.
        for (int k = 0; k < 3; k++) add_pixel(8'hFF, k == 0, 1'b0, '0);
        add_pixel(8'h5A, 1'b0, 1'b0, '0);
        add_pixel(8'hA5, 1'b0, 1'b0, '0);
        add_pixel(8'h3C, 1'b0, 1'b0, '0);
        add_pixel(8'h00, 1'b0, 1'b0, '0);
        add_pixel(8'h00, 1'b0, 1'b0, '0);
        add_pixel(8'h00, 1'b0, 1'b1, {8'hFF, 1'b1, 1'b1});
        // Next frame with no start mark: the counters wrap by themselves. Black over white
        // saturates low.
        for (int k = 0; k < 3; k++) add_pixel(8'h00, 1'b0, 1'b0, '0);
        add_pixel(8'hC3, 1'b0, 1'b0, '0);
        add_pixel(8'h96, 1'b0, 1'b0, '0);
        add_pixel(8'h69, 1'b0, 1'b0, '0);
        add_pixel(8'hFF, 1'b0, 1'b0, '0);
        add_pixel(8'hFF, 1'b0, 1'b0, '0);
        add_pixel(8'hFF, 1'b0, 1'b1, {8'h00, 1'b1, 1'b1});
        // A frame left unfinished; the next phase restarts it with a start mark.
        add_pixel(8'h12, 1'b0, 1'b0, '0);
        add_pixel(8'hED, 1'b0, 1'b0, '0);
        add_pixel(8'h80, 1'b0, 1'b0, '0);
        add_pixel(8'h7F, 1'b0, 1'b0, '0);
        foreach (directed_rows[n]) begin
            if (directed_rows[n].is_write) begin
                write_reg(directed_rows[n].reg_idx, directed_rows[n].reg_val);
            end else begin
                send_pixel(directed_rows[n].pix, directed_rows[n].sof,
                           directed_rows[n].typed, directed_rows[n].want);
            end
        end

        // Random small frames, sizes occasionally below the legal range.
        for (int p = 0; p < 8; p++) begin
            w_val = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(0, 2))
                                                : DIM_W'($urandom_range(3, 8));
            h_val = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(0, 2))
                                                : DIM_W'($urandom_range(3, 5));
            steady = ($urandom_range(0, 4) == 0);
            write_reg(CFG_IDX_WIDTH, w_val);
            write_reg(CFG_IDX_HEIGHT, h_val);
            frame_px = clamp_dim(w_val, MAX_WIDTH) * clamp_dim(h_val, MAX_HEIGHT);
            run_stream(frame_px * $urandom_range(1, 2) + $urandom_range(0, 6), 1'b1);
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every stall at its longest.
    initial begin : watchdog_proc
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sobv_pkg.sv
rtl/sobv_ram.sv
rtl/sobv_cell.sv
rtl/sobv_fifo.sv
rtl/sobel_vertical_edge_filter_top.sv
tb/sobel_vertical_edge_filter_top_test.sv
